[hdl/psd_pkg.sv]
// Shared types, widths and case codes for the point to segment distance pipeline.
// No dependencies; used by every module of the block.
package psd_pkg;

    localparam int CW   = 16;   // coordinate width
    localparam int DW   = CW + 1;   // coordinate difference width
    localparam int PW   = 2 * DW;   // product of two differences
    localparam int SW   = PW + 2;   // sum of three signed products
    localparam int QW   = DW;       // quotient width
    localparam int NW   = PW + QW + 1; // dividend width
    localparam int DVW  = PW + 1;   // divisor width (twice the squared length)
    localparam int XW   = PW + 2;   // square root working width
    localparam int RW   = DW;       // square root result width
    localparam int CASE_BITS = 3;

    localparam logic [CASE_BITS-1:0] CASE_DEGEN    = 3'd0;
    localparam logic [CASE_BITS-1:0] CASE_ON_END   = 3'd1;
    localparam logic [CASE_BITS-1:0] CASE_END_A    = 3'd2;
    localparam logic [CASE_BITS-1:0] CASE_END_B    = 3'd3;
    localparam logic [CASE_BITS-1:0] CASE_INTERIOR = 3'd4;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t [2:0]         p;
        coord_t [2:0]         a;
        coord_t [2:0]         b;
        logic [CASE_BITS-1:0] code;
        logic [2:0]           neg;
    } div_side_t;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QW-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic             valid;
        div_side_t        side;
        logic [DVW-1:0]   dvs;
        div_lane_t [2:0]  lane;
    } div_stage_t;

    typedef struct packed {
        logic                 valid;
        coord_t [2:0]         near;
        logic [CASE_BITS-1:0] code;
        logic [XW-1:0]        x;
        logic [XW-1:0]        res;
    } sqrt_stage_t;

endpackage

[hdl/psd_div_cell.sv]
// One restoring division cell: settles one quotient bit for each of three axes.
// Depends on psd_pkg.
module psd_div_cell
    import psd_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  div_stage_t in_stage,
    output div_stage_t out_stage
);

    div_stage_t stage_reg;
    div_stage_t stage_next;
    logic [NW-1:0] dvs_shifted;
    logic [NW:0]   trial [3];

    assign dvs_shifted = NW'(in_stage.dvs) << SHIFT;

    always_comb begin
        stage_next = in_stage;
        for (int j = 0; j < 3; j++) begin
            trial[j] = {1'b0, in_stage.lane[j].rem} - {1'b0, dvs_shifted};
            if (!trial[j][NW]) begin
                stage_next.lane[j].rem = trial[j][NW-1:0];
                stage_next.lane[j].quo = {in_stage.lane[j].quo[QW-2:0], 1'b1};
            end else begin
                stage_next.lane[j].quo = {in_stage.lane[j].quo[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_stage = stage_reg;

endmodule

[hdl/psd_sqrt_cell.sv]
// One digit-by-digit integer square root cell: settles one result bit.
// Depends on psd_pkg.
module psd_sqrt_cell
    import psd_pkg::*;
#(
    parameter int K = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  sqrt_stage_t in_stage,
    output sqrt_stage_t out_stage
);

    sqrt_stage_t stage_reg;
    sqrt_stage_t stage_next;
    logic [XW-1:0] bit_val;
    logic [XW-1:0] trial;

    assign bit_val = XW'(1) << (2 * K);
    assign trial   = in_stage.res + bit_val;

    always_comb begin
        stage_next = in_stage;
        if (in_stage.x >= trial) begin
            stage_next.x   = in_stage.x - trial;
            stage_next.res = (in_stage.res >> 1) + bit_val;
        end else begin
            stage_next.res = in_stage.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_stage = stage_reg;

endmodule

[hdl/point_segment_distance_3d.sv]
// Top level of the point to 3-D segment distance pipeline.
// Depends on psd_pkg, psd_div_cell and psd_sqrt_cell.
//
//   channel  | dir | payload (low bit first)
//   s_axis   | in  | query xyz, end A xyz, end B xyz (9 x 16 bits)
//   m_axis   | out | near xyz (3 x 16), distance (17), case code (3), pad
//
// One transfer is taken every cycle while the output is not stalled; a result passes
// through 9 setup stages, a 17-cell divider chain, a 17-cell square root chain and
// the output register. Reset clears all stage valid bits at once.
// A stalled output freezes the whole pipeline; s_tready follows that freeze.
module point_segment_distance_3d
    import psd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // query_x, query_y, query_z, end_a_x..z, end_b_x..z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // near_x, near_y, near_z, distance, case_code, zero pad
);

    logic en;
    logic m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage 1: differences and equality flags
    logic v1_reg;
    coord_t p1_reg [3], a1_reg [3], b1_reg [3];
    logic signed [DW-1:0] ab1_reg [3], pa1_reg [3], pb1_reg [3];
    logic eq_ab1_reg, eq_pe1_reg;
    coord_t in_p [3], in_a [3], in_b [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            in_p[j] = s_tdata[CW*j +: CW];
            in_a[j] = s_tdata[CW*(3+j) +: CW];
            in_b[j] = s_tdata[CW*(6+j) +: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                p1_reg[j]  <= in_p[j];
                a1_reg[j]  <= in_a[j];
                b1_reg[j]  <= in_b[j];
                ab1_reg[j] <= DW'(in_b[j]) - DW'(in_a[j]);
                pa1_reg[j] <= DW'(in_p[j]) - DW'(in_a[j]);
                pb1_reg[j] <= DW'(in_p[j]) - DW'(in_b[j]);
            end
            eq_ab1_reg <= (in_a[0] == in_b[0]) && (in_a[1] == in_b[1]) && (in_a[2] == in_b[2]);
            eq_pe1_reg <= ((in_p[0] == in_a[0]) && (in_p[1] == in_a[1]) && (in_p[2] == in_a[2]))
                       || ((in_p[0] == in_b[0]) && (in_p[1] == in_b[1])
                           && (in_p[2] == in_b[2]));
        end
    end

    // stage 2: products
    logic v2_reg;
    coord_t p2_reg [3], a2_reg [3], b2_reg [3];
    logic signed [DW-1:0] ab2_reg [3];
    logic signed [PW-1:0] dot2_reg [3];
    logic [PW-1:0] sab2_reg [3], spa2_reg [3], spb2_reg [3];
    logic eq_ab2_reg, eq_pe2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                p2_reg[j]   <= p1_reg[j];
                a2_reg[j]   <= a1_reg[j];
                b2_reg[j]   <= b1_reg[j];
                ab2_reg[j]  <= ab1_reg[j];
                dot2_reg[j] <= ab1_reg[j] * pa1_reg[j];
                sab2_reg[j] <= PW'(ab1_reg[j] * ab1_reg[j]);
                spa2_reg[j] <= PW'(pa1_reg[j] * pa1_reg[j]);
                spb2_reg[j] <= PW'(pb1_reg[j] * pb1_reg[j]);
            end
            eq_ab2_reg <= eq_ab1_reg;
            eq_pe2_reg <= eq_pe1_reg;
        end
    end

    // stage 3: sums
    logic v3_reg;
    coord_t p3_reg [3], a3_reg [3], b3_reg [3];
    logic signed [DW-1:0] ab3_reg [3];
    logic signed [SW-1:0] num3_reg;
    logic [PW-1:0] den3_reg, da3_reg, db3_reg;
    logic eq_ab3_reg, eq_pe3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                p3_reg[j]  <= p2_reg[j];
                a3_reg[j]  <= a2_reg[j];
                b3_reg[j]  <= b2_reg[j];
                ab3_reg[j] <= ab2_reg[j];
            end
            num3_reg <= SW'(dot2_reg[0]) + SW'(dot2_reg[1]) + SW'(dot2_reg[2]);
            den3_reg <= sab2_reg[0] + sab2_reg[1] + sab2_reg[2];
            da3_reg  <= spa2_reg[0] + spa2_reg[1] + spa2_reg[2];
            db3_reg  <= spb2_reg[0] + spb2_reg[1] + spb2_reg[2];
            eq_ab3_reg <= eq_ab2_reg;
            eq_pe3_reg <= eq_pe2_reg;
        end
    end

    // stage 4: case decision and split products for the projection
    logic v4_reg;
    coord_t p4_reg [3], a4_reg [3], b4_reg [3];
    logic [PW-1:0] den4_reg;
    logic signed [DW+DW:0] mlo4_reg [3], mhi4_reg [3];
    logic [CASE_BITS-1:0] code4_reg;
    logic [CASE_BITS-1:0] code_next;
    logic num_out;

    assign num_out = num3_reg[SW-1] || ($unsigned(num3_reg) > SW'(den3_reg));

    always_comb begin
        if (eq_ab3_reg) begin
            code_next = CASE_DEGEN;
        end else if (eq_pe3_reg) begin
            code_next = CASE_ON_END;
        end else if (num_out) begin
            code_next = (da3_reg < db3_reg) ? CASE_END_A : CASE_END_B;
        end else begin
            code_next = CASE_INTERIOR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                p4_reg[j]   <= p3_reg[j];
                a4_reg[j]   <= a3_reg[j];
                b4_reg[j]   <= b3_reg[j];
                mlo4_reg[j] <= ab3_reg[j] * $signed({1'b0, num3_reg[DW-1:0]});
                mhi4_reg[j] <= ab3_reg[j] * $signed({1'b0, num3_reg[PW-1:DW]});
            end
            den4_reg  <= den3_reg;
            code4_reg <= code_next;
        end
    end

    // stage 5: rounded dividend, feeds the divider chain
    localparam int MW = NW + 1;
    div_stage_t div_chain [QW+1];
    div_stage_t div_in_next;
    logic signed [MW-1:0] prod_full [3];
    logic [MW-1:0] prod_mag [3];

    always_comb begin
        div_in_next.valid = v4_reg;
        div_in_next.dvs   = {den4_reg, 1'b0};
        div_in_next.side.code = code4_reg;
        for (int j = 0; j < 3; j++) begin
            prod_full[j] = (MW'(mhi4_reg[j]) <<< DW) + MW'(mlo4_reg[j]);
            prod_mag[j]  = prod_full[j][MW-1] ? MW'(-prod_full[j]) : MW'(prod_full[j]);
            div_in_next.side.p[j] = p4_reg[j];
            div_in_next.side.a[j] = a4_reg[j];
            div_in_next.side.b[j] = b4_reg[j];
            div_in_next.side.neg[j] = prod_full[j][MW-1];
            div_in_next.lane[j].rem = {prod_mag[j][NW-2:0], 1'b0} + NW'(den4_reg);
            div_in_next.lane[j].quo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_chain[0].valid <= 1'b0;
        end else if (en) begin
            div_chain[0] <= div_in_next;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_div
        psd_div_cell #(
            .SHIFT(QW - 1 - i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_stage (div_chain[i]),
            .out_stage(div_chain[i+1])
        );
    end

    // stage 6: nearest point
    div_stage_t div_out;
    logic v6_reg;
    coord_t p6_reg [3], nr6_reg [3];
    logic [CASE_BITS-1:0] code6_reg;
    coord_t nr_next [3];
    logic signed [DW:0] step [3];

    assign div_out = div_chain[QW];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            step[j] = div_out.side.neg[j] ? -$signed({2'b00, div_out.lane[j].quo[QW-2:0]})
                                          : $signed({2'b00, div_out.lane[j].quo[QW-2:0]});
            case (div_out.side.code)
                CASE_ON_END:   nr_next[j] = div_out.side.p[j];
                CASE_END_B:    nr_next[j] = div_out.side.b[j];
                CASE_INTERIOR: nr_next[j] = CW'((DW+1)'(div_out.side.a[j]) + step[j]);
                default:       nr_next[j] = div_out.side.a[j];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= div_out.valid;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                p6_reg[j]  <= div_out.side.p[j];
                nr6_reg[j] <= nr_next[j];
            end
            code6_reg <= div_out.side.code;
        end
    end

    // stages 7 to 9: difference, squares, sum
    logic v7_reg, v8_reg;
    coord_t nr7_reg [3], nr8_reg [3];
    logic [CASE_BITS-1:0] code7_reg, code8_reg;
    logic signed [DW-1:0] d7_reg [3];
    logic [PW-1:0] sq8_reg [3];
    sqrt_stage_t sqrt_chain [RW+1];
    sqrt_stage_t sqrt_in_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                nr7_reg[j] <= nr6_reg[j];
                d7_reg[j]  <= DW'(nr6_reg[j]) - DW'(p6_reg[j]);
                nr8_reg[j] <= nr7_reg[j];
                sq8_reg[j] <= PW'(d7_reg[j] * d7_reg[j]);
            end
            code7_reg <= code6_reg;
            code8_reg <= code7_reg;
        end
    end

    always_comb begin
        sqrt_in_next.valid = v8_reg;
        sqrt_in_next.code  = code8_reg;
        for (int j = 0; j < 3; j++) begin
            sqrt_in_next.near[j] = nr8_reg[j];
        end
        sqrt_in_next.x   = (code8_reg == CASE_ON_END) ? '0
                         : XW'(sq8_reg[0]) + XW'(sq8_reg[1]) + XW'(sq8_reg[2]);
        sqrt_in_next.res = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqrt_chain[0].valid <= 1'b0;
        end else if (en) begin
            sqrt_chain[0] <= sqrt_in_next;
        end
    end

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        psd_sqrt_cell #(
            .K(RW - 1 - i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_stage (sqrt_chain[i]),
            .out_stage(sqrt_chain[i+1])
        );
    end

    // output register
    sqrt_stage_t sqrt_out;
    assign sqrt_out = sqrt_chain[RW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= sqrt_out.valid;
        end
        if (en) begin
            m_tdata_reg <= {4'b0000, sqrt_out.code, sqrt_out.res[RW-1:0],
                            sqrt_out.near[2], sqrt_out.near[1], sqrt_out.near[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[tb/testbench.sv]
// Testbench for point_segment_distance_3d: drives random and directed segment queries,
// predicts nearest point, distance and case code, and checks each result transfer.
// Depends on psd_pkg and the point_segment_distance_3d RTL.
module testbench;
    import psd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] nx, ny, nz;
        logic [16:0]        distance;
        logic [2:0]         code;
    } nearest_t;

    class nearest_board;
        nearest_t pending[$];
        int       errors = 0;
        int       checked = 0;
        int       code_seen[5];

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint sq3(longint u[3], longint v[3]);
            longint s;
            s = 0;
            for (int i = 0; i < 3; i++) s += (u[i] - v[i]) * (u[i] - v[i]);
            return s;
        endfunction

        function longint rdiv(longint n, longint d);
            longint m, q;
            m = (n < 0) ? -n : n;
            q = (2 * m + d) / (2 * d);
            return (n < 0) ? -q : q;
        endfunction

        function void note(logic [143:0] data);
            longint p[3], a[3], b[3], nr[3], ab[3];
            longint num, den, d2;
            logic [2:0] code;
            nearest_t e;
            for (int i = 0; i < 3; i++) begin
                p[i] = $signed(data[16*i +: 16]);
                a[i] = $signed(data[16*(3+i) +: 16]);
                b[i] = $signed(data[16*(6+i) +: 16]);
                nr[i] = a[i];
                ab[i] = b[i] - a[i];
            end
            if (a == b) begin
                code = CASE_DEGEN;
            end else if (p == a || p == b) begin
                nr = p;
                code = CASE_ON_END;
            end else begin
                num = 0;
                den = 0;
                for (int i = 0; i < 3; i++) begin
                    num += ab[i] * (p[i] - a[i]);
                    den += ab[i] * ab[i];
                end
                if (num < 0 || num > den) begin
                    if (sq3(p, a) < sq3(p, b)) begin
                        code = CASE_END_A;
                    end else begin
                        nr = b;
                        code = CASE_END_B;
                    end
                end else begin
                    for (int i = 0; i < 3; i++) nr[i] = a[i] + rdiv(ab[i] * num, den);
                    code = CASE_INTERIOR;
                end
            end
            d2 = (code == CASE_ON_END) ? 0 : sq3(nr, p);
            e.nx = nr[0][15:0];
            e.ny = nr[1][15:0];
            e.nz = nr[2][15:0];
            e.distance = 17'(isqrt(d2));
            e.code = code;
            code_seen[code]++;
            pending.push_back(e);
        endfunction

        function void check(logic [71:0] data);
            nearest_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (data[15:0] !== e.nx) begin
                $display("%0t: near_x exp %h got %h", $time, e.nx, data[15:0]);
                errors++;
            end
            if (data[31:16] !== e.ny) begin
                $display("%0t: near_y exp %h got %h", $time, e.ny, data[31:16]);
                errors++;
            end
            if (data[47:32] !== e.nz) begin
                $display("%0t: near_z exp %h got %h", $time, e.nz, data[47:32]);
                errors++;
            end
            if (data[64:48] !== e.distance) begin
                $display("%0t: distance exp %0d got %0d", $time, e.distance, data[64:48]);
                errors++;
            end
            if (data[67:65] !== e.code) begin
                $display("%0t: case_code exp %0d got %0d", $time, e.code, data[67:65]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [71:0]  m_tdata;

    nearest_board board = new();
    bit           hold_off = 0;
    bit           src_done = 0;
    int           idle_cycles = 0;
    localparam int WATCHDOG = 5000;

    point_segment_distance_3d dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    function logic [15:0] rnd_coord(int span);
        if (span == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send(logic [143:0] d, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (($urandom_range(0, 3) == 0) || !gaps) g = 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        board.note(d);
    endtask

    function logic [143:0] pack(logic [15:0] p[3], logic [15:0] a[3], logic [15:0] b[3]);
        return {b[2], b[1], b[0], a[2], a[1], a[0], p[2], p[1], p[0]};
    endfunction

    task automatic random_item(bit gaps);
        logic [15:0] p[3], a[3], b[3];
        int kind, span;
        kind = $urandom_range(0, 19);
        span = ($urandom_range(0, 2) == 0) ? 0 : (1 << $urandom_range(2, 14));
        for (int i = 0; i < 3; i++) begin
            p[i] = rnd_coord(span);
            a[i] = rnd_coord(span);
            b[i] = rnd_coord(span);
        end
        if (kind == 0) b = a;
        else if (kind == 1) p = a;
        else if (kind == 2) p = b;
        else if (kind == 3) begin
            for (int i = 0; i < 3; i++) p[i] = 16'(2 * a[i] - b[i]);
        end
        send(pack(p, a, b), gaps);
    endtask

    task automatic directed();
        logic [15:0] mx[3], mn[3], z[3], o[3], t[3];
        mx = '{16'h7fff, 16'h7fff, 16'h7fff};
        mn = '{16'h8000, 16'h8000, 16'h8000};
        z  = '{16'h0, 16'h0, 16'h0};
        o  = '{16'h10, 16'h0, 16'h0};
        t  = '{16'h20, 16'h0, 16'h0};
        send(pack(mx, mn, mn), 0);
        send(pack(mn, mx, mx), 0);
        send(pack(mn, mx, mn), 0);
        send(pack(mx, mn, mx), 0);
        send(pack(mn, mn, mx), 0);
        send(pack(mx, mx, mn), 0);
        send(pack(z, z, z), 0);
        send(pack(z, z, t), 0);
        send(pack(t, z, t), 0);
        send(pack(o, z, t), 0);
        send(pack('{16'h8, 16'h5, 16'h0}, z, t), 0);
        send(pack('{16'hfff0, 16'h0, 16'h0}, z, t), 0);
        send(pack('{16'h30, 16'h0, 16'h0}, z, t), 0);
        send(pack('{16'h0, 16'h10, 16'h0}, '{16'hfff0, 16'h0, 16'h0}, o), 0);
        send(pack('{16'h1, 16'h3, 16'h0}, z, '{16'h3, 16'h0, 16'h0}), 0);
        send(pack('{16'hffff, 16'h7, 16'h5}, z, '{16'h3, 16'h0, 16'h0}), 0);
        send(pack('{16'h5, 16'h1, 16'h2}, '{16'h7, 16'h0, 16'h0}, z), 0);
        send(pack(z, mn, mx), 0);
        send(pack(z, '{16'h8000, 16'h7fff, 16'h8000}, '{16'h7fff, 16'h8000, 16'h7fff}), 0);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        directed();
        repeat (500) random_item(1);
        hold_off = 1;
        repeat (200) random_item(0);
        hold_off = 0;
        s_tvalid <= 0;
        wait (board.pending.size() == 0);
        repeat (600) random_item(1);
        repeat (50) random_item(0);
        s_tvalid <= 0;
        src_done = 1;
    end

    initial begin
        int g;
        bit held;
        held = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off && !held) begin
                held = 1;
                @(posedge aclk);
                m_tready <= 0;
                repeat (300) @(posedge aclk);
            end
            g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            repeat (g) begin
                @(posedge aclk);
                m_tready <= 0;
            end
            @(posedge aclk);
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        wait (src_done);
        wait (board.pending.size() == 0);
        repeat (100) @(posedge aclk);
        $display("Checked %0d results: degenerate %0d, on end %0d, end A %0d, end B %0d",
                 board.checked, board.code_seen[0], board.code_seen[1],
                 board.code_seen[2], board.code_seen[3]);
        $display("interior %0d, with random stalls and a long output hold-off",
                 board.code_seen[4]);
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
